[hw/rtl/iss_pkg.sv]
package iss_pkg;

   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_S      = 8'h73;
   localparam logic [7:0] CHAR_E      = 8'h65;

   typedef struct packed {
      logic slash;
      logic star;
      logic quote;
      logic bslash;
      logic newline;
      logic space;
      logic tab;
      logic semi;
      logic u;
      logic s;
      logic e;
      logic boundary;
      logic blank;
      logic eof;
   } byte_class_type;

   typedef struct packed {
      logic store;
      logic clear;
      logic start;
      logic read;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
   } dp_status_type;

endpackage

[hw/rtl/iss_datapath.sv]
module iss_datapath #(
   parameter int MAX_NAME = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   output iss_pkg::byte_class_type cls,
   input  iss_pkg::dp_cmd_type    cmd,
   output iss_pkg::dp_status_type status,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);
   import iss_pkg::*;

   localparam int AW   = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
   localparam int LENW = $clog2(MAX_NAME + 1);

   logic [7:0]      mem [MAX_NAME];
   logic [LENW-1:0] stored_ff;
   logic [LENW-1:0] trimmed_ff;
   logic            overflowed_ff;
   logic [AW-1:0]   rd_ptr_ff;
   logic [7:0]      rd_data_ff;
   logic            last_ff;
   logic [LENW-1:0] count;
   logic [LENW:0]   next_idx;
   logic            has_room;

   always_comb begin
      cls.slash    = (req_tdata == CHAR_SLASH);
      cls.star     = (req_tdata == CHAR_STAR);
      cls.quote    = (req_tdata == CHAR_QUOTE);
      cls.bslash   = (req_tdata == CHAR_BSLASH);
      cls.newline  = (req_tdata == CHAR_NL);
      cls.space    = (req_tdata == CHAR_SPACE);
      cls.tab      = (req_tdata == CHAR_TAB);
      cls.semi     = (req_tdata == CHAR_SEMI);
      cls.u        = (req_tdata == CHAR_U);
      cls.s        = (req_tdata == CHAR_S);
      cls.e        = (req_tdata == CHAR_E);
      cls.boundary = cls.newline | cls.space | cls.tab | cls.semi | (req_tdata == CHAR_RBRACE);
      cls.blank    = cls.space | cls.tab | (req_tdata == CHAR_CR);
      cls.eof      = req_tlast;
   end

   assign count        = overflowed_ff ? LENW'(MAX_NAME) : trimmed_ff;
   assign next_idx     = (LENW+1)'(rd_ptr_ff) + 1'b1;
   assign has_room     = (stored_ff < LENW'(MAX_NAME));
   assign status.empty = (count == '0);
   assign status.last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff     <= '0;
         trimmed_ff    <= '0;
         overflowed_ff <= 1'b0;
      end else if (cmd.clear) begin
         stored_ff     <= '0;
         trimmed_ff    <= '0;
         overflowed_ff <= 1'b0;
      end else if (cmd.store) begin
         if (has_room) begin
            stored_ff <= stored_ff + 1'b1;
            if (!cls.blank) begin
               trimmed_ff <= stored_ff + 1'b1;
            end
         end else if (!cls.blank) begin
            overflowed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store && has_room) begin
         mem[stored_ff[AW-1:0]] <= req_tdata;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[rd_ptr_ff];
         last_ff    <= (next_idx == (LENW+1)'(count));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_ptr_ff <= '0;
      end else if (cmd.advance) begin
         rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   assign rsp_tdata = rd_data_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tuser = overflowed_ff;

endmodule

[hw/rtl/iss_controller.sv]
module iss_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  iss_pkg::byte_class_type cls,
   input  iss_pkg::dp_status_type  status,
   output iss_pkg::dp_cmd_type     cmd
);
   import iss_pkg::*;

   typedef enum logic [3:0] {
      SC_NORMAL,
      SC_SLASH,
      SC_LINE,
      SC_BLOCK,
      SC_BLOCK_STAR,
      SC_STRING,
      SC_STRING_ESC,
      SC_USE_U,
      SC_USE_S,
      SC_USE_E,
      SC_SKIP_WS,
      SC_CAPTURE
   } scan_mode_type;

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_START,
      PH_READ,
      PH_SHOW
   } phase_type;

   scan_mode_type mode_ff, mode_in;
   logic          prev_ff, prev_in;
   phase_type     phase_ff, phase_in;
   logic          accept;
   logic          use_normal;
   logic          normal_bb;
   logic          capture;
   logic          trigger;
   logic          scan_clear;
   logic          store;

   assign req_tready = (phase_ff == PH_SCAN);
   assign rsp_tvalid = (phase_ff == PH_SHOW);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      mode_in    = mode_ff;
      prev_in    = prev_ff;
      use_normal = 1'b0;
      normal_bb  = 1'b0;
      capture    = 1'b0;
      trigger    = 1'b0;
      scan_clear = 1'b0;
      store      = 1'b0;
      if (accept) begin
         unique case (mode_ff)
            SC_SLASH: begin
               if (cls.slash) begin
                  mode_in = SC_LINE;
               end else if (cls.star) begin
                  mode_in = SC_BLOCK;
               end else begin
                  use_normal = 1'b1;
               end
            end
            SC_LINE: begin
               if (cls.newline) begin
                  mode_in = SC_NORMAL;
                  prev_in = 1'b1;
               end
            end
            SC_BLOCK: begin
               if (cls.star) begin
                  mode_in = SC_BLOCK_STAR;
               end
            end
            SC_BLOCK_STAR: begin
               if (cls.slash) begin
                  mode_in = SC_NORMAL;
                  prev_in = 1'b0;
               end else if (!cls.star) begin
                  mode_in = SC_BLOCK;
               end
            end
            SC_STRING: begin
               if (cls.bslash) begin
                  mode_in = SC_STRING_ESC;
               end else if (cls.quote) begin
                  mode_in = SC_NORMAL;
                  prev_in = 1'b0;
               end
            end
            SC_STRING_ESC: begin
               mode_in = SC_STRING;
            end
            SC_USE_U: begin
               if (cls.s) begin
                  mode_in = SC_USE_S;
               end else begin
                  use_normal = 1'b1;
               end
            end
            SC_USE_S: begin
               if (cls.e) begin
                  mode_in = SC_USE_E;
               end else begin
                  use_normal = 1'b1;
               end
            end
            SC_USE_E: begin
               if (cls.space) begin
                  mode_in    = SC_SKIP_WS;
                  scan_clear = 1'b1;
               end else begin
                  use_normal = 1'b1;
               end
            end
            SC_SKIP_WS: begin
               capture = !(cls.space | cls.tab);
            end
            SC_CAPTURE: begin
               capture = 1'b1;
            end
            default: begin
               use_normal = 1'b1;
               normal_bb  = prev_ff;
            end
         endcase

         if (use_normal) begin
            if (cls.slash) begin
               mode_in = SC_SLASH;
            end else if (cls.quote) begin
               mode_in = SC_STRING;
            end else if (cls.u && normal_bb) begin
               mode_in = SC_USE_U;
            end else begin
               mode_in = SC_NORMAL;
               prev_in = cls.boundary;
            end
         end

         if (capture) begin
            if (cls.semi || cls.newline) begin
               trigger = 1'b1;
               mode_in = SC_NORMAL;
               prev_in = 1'b1;
            end else begin
               mode_in = SC_CAPTURE;
               store   = 1'b1;
            end
         end

         if (cls.eof) begin
            if (mode_in == SC_CAPTURE) begin
               trigger = 1'b1;
            end
            mode_in = SC_NORMAL;
            prev_in = 1'b1;
            if (!trigger) begin
               scan_clear = 1'b1;
            end
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      cmd.store   = store;
      cmd.clear   = scan_clear;
      cmd.start   = 1'b0;
      cmd.read    = 1'b0;
      cmd.advance = 1'b0;
      unique case (phase_ff)
         PH_SCAN: begin
            if (trigger) begin
               phase_in = PH_START;
            end
         end
         PH_START: begin
            if (status.empty) begin
               cmd.clear = 1'b1;
               phase_in  = PH_SCAN;
            end else begin
               cmd.start = 1'b1;
               phase_in  = PH_READ;
            end
         end
         PH_READ: begin
            cmd.read = 1'b1;
            phase_in = PH_SHOW;
         end
         PH_SHOW: begin
            if (rsp_tready) begin
               if (status.last) begin
                  cmd.clear = 1'b1;
                  phase_in  = PH_SCAN;
               end else begin
                  cmd.advance = 1'b1;
                  phase_in    = PH_READ;
               end
            end
         end
         default: begin
            phase_in = PH_SCAN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= SC_NORMAL;
         prev_ff  <= 1'b1;
         phase_ff <= PH_SCAN;
      end else begin
         mode_ff  <= mode_in;
         prev_ff  <= prev_in;
         phase_ff <= phase_in;
      end
   end

endmodule

[hw/rtl/import_statement_scanner.sv]
// Channel | Direction | Word                 | Sideband
// req_    | in        | tdata[7:0] source    | tlast = end of file
// rsp_    | out       | tdata[7:0] name byte | tlast = last name byte, tuser = truncated
//
// While scanning, one source word is accepted every cycle.
// A name ends scanning: the scanner checks its length, then reads each byte
// from the name buffer and presents it until rsp_tready takes it.
// An empty name is dropped after the length check, with no output.
// Reset is synchronous; rsp_tready low simply holds the current name byte.
module import_statement_scanner #(
   parameter int MAX_NAME = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] name_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] name_truncated
);
   import iss_pkg::*;

   byte_class_type cls;
   dp_cmd_type     cmd;
   dp_status_type  status;

   iss_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cls        (cls),
      .status     (status),
      .cmd        (cmd)
   );

   iss_datapath #(
      .MAX_NAME (MAX_NAME)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .cls       (cls),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

[hw/rtl/iss_checker.sv]
module iss_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // A waiting name byte holds until it is taken.
   hold_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // No source word is taken while a name is being sent.
   no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("req accepted during name output");

   // After a non-final name byte, the next one follows and input stays closed.
   next_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready ##1 rsp_tvalid)
      else $error("name output broke off early");

   // The truncation flag is the same on every byte of one name.
   trunc_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> ##1 rsp_tuser == $past(rsp_tuser, 2))
      else $error("truncation flag changed within a name");

endmodule

bind import_statement_scanner iss_checker u_iss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[sim/testbench.sv]
module testbench;
   import iss_pkg::*;

   localparam int NAME_CAP = 64;
   localparam int IDX_W    = $clog2(NAME_CAP);
   localparam int HOLD_LEN = 300;

   typedef enum logic [3:0] {
      SCAN_NORMAL,
      SCAN_SLASH,
      SCAN_LINE,
      SCAN_BLOCK,
      SCAN_BLOCK_STAR,
      SCAN_STRING,
      SCAN_STRING_ESC,
      SCAN_USE_U,
      SCAN_USE_S,
      SCAN_USE_E,
      SCAN_SKIP_WS,
      SCAN_CAPTURE
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       last;
      logic       truncated;
   } name_word_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   scan_mode_type scan_mode;
   logic          boundary_prev;
   logic [7:0]    name_buf [NAME_CAP];
   int unsigned   held_len;
   int unsigned   trim_len;
   logic          name_cut;

   name_word_type name_words_due [$];
   logic [7:0]    src_bytes [$];
   int            failures = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            hold_asks = 0;
   int            hold_done = 0;
   int            hold_left = 0;

   import_statement_scanner #(
      .MAX_NAME(NAME_CAP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic is_boundary_char(input logic [7:0] c);
      return c == CHAR_NL || c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_SEMI ||
         c == CHAR_RBRACE;
   endfunction

   function automatic logic is_blank_char(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR;
   endfunction

   function void reset_scanner();
      scan_mode = SCAN_NORMAL;
      boundary_prev = 1'b1;
      held_len = 0;
      trim_len = 0;
      name_cut = 1'b0;
   endfunction

   function void scan_plain(input logic [7:0] c, input logic boundary_before);
      if (c == CHAR_SLASH) begin
         scan_mode = SCAN_SLASH;
      end else if (c == CHAR_QUOTE) begin
         scan_mode = SCAN_STRING;
      end else if (c == CHAR_U && boundary_before) begin
         scan_mode = SCAN_USE_U;
      end else begin
         scan_mode = SCAN_NORMAL;
         boundary_prev = is_boundary_char(c);
      end
   endfunction

   function void emit_name();
      int unsigned count;
      name_word_type w;
      count = name_cut ? NAME_CAP : trim_len;
      for (int k = 0; k < count; k++) begin
         w.name_byte = name_buf[k[IDX_W-1:0]];
         w.last = (k + 1 == count);
         w.truncated = name_cut;
         name_words_due.insert(name_words_due.size(), w);
      end
      held_len = 0;
      trim_len = 0;
      name_cut = 1'b0;
   endfunction

   function void capture_char(input logic [7:0] c);
      if (c == CHAR_SEMI || c == CHAR_NL) begin
         emit_name();
         scan_mode = SCAN_NORMAL;
         boundary_prev = 1'b1;
      end else begin
         scan_mode = SCAN_CAPTURE;
         if (held_len < NAME_CAP) begin
            name_buf[held_len[IDX_W-1:0]] = c;
            held_len++;
            if (!is_blank_char(c)) trim_len = held_len;
         end else if (!is_blank_char(c)) begin
            name_cut = 1'b1;
         end
      end
   endfunction

   function void predict_byte(input logic [7:0] c, input logic eof);
      case (scan_mode)
         SCAN_SLASH: begin
            if (c == CHAR_SLASH) scan_mode = SCAN_LINE;
            else if (c == CHAR_STAR) scan_mode = SCAN_BLOCK;
            else scan_plain(c, 1'b0);
         end
         SCAN_LINE: begin
            if (c == CHAR_NL) begin
               scan_mode = SCAN_NORMAL;
               boundary_prev = 1'b1;
            end
         end
         SCAN_BLOCK: begin
            if (c == CHAR_STAR) scan_mode = SCAN_BLOCK_STAR;
         end
         SCAN_BLOCK_STAR: begin
            if (c == CHAR_SLASH) begin
               scan_mode = SCAN_NORMAL;
               boundary_prev = 1'b0;
            end else if (c != CHAR_STAR) begin
               scan_mode = SCAN_BLOCK;
            end
         end
         SCAN_STRING: begin
            if (c == CHAR_BSLASH) begin
               scan_mode = SCAN_STRING_ESC;
            end else if (c == CHAR_QUOTE) begin
               scan_mode = SCAN_NORMAL;
               boundary_prev = 1'b0;
            end
         end
         SCAN_STRING_ESC: scan_mode = SCAN_STRING;
         SCAN_USE_U: begin
            if (c == CHAR_S) scan_mode = SCAN_USE_S;
            else scan_plain(c, 1'b0);
         end
         SCAN_USE_S: begin
            if (c == CHAR_E) scan_mode = SCAN_USE_E;
            else scan_plain(c, 1'b0);
         end
         SCAN_USE_E: begin
            if (c == CHAR_SPACE) begin
               scan_mode = SCAN_SKIP_WS;
               held_len = 0;
               trim_len = 0;
               name_cut = 1'b0;
            end else begin
               scan_plain(c, 1'b0);
            end
         end
         SCAN_SKIP_WS: begin
            if (c != CHAR_SPACE && c != CHAR_TAB) capture_char(c);
         end
         SCAN_CAPTURE: capture_char(c);
         default: scan_plain(c, boundary_prev);
      endcase
      if (eof) begin
         if (scan_mode == SCAN_CAPTURE) emit_name();
         reset_scanner();
      end
   endfunction

   function void check_word();
      name_word_type want;
      if (name_words_due.size() == 0) begin
         $error("unexpected name word %h (last %b, truncated %b)", rsp_tdata, rsp_tlast,
            rsp_tuser);
         failures++;
      end else begin
         want = name_words_due.pop_front();
         if (rsp_tdata !== want.name_byte) begin
            $error("name_byte: expected %h, got %h", want.name_byte, rsp_tdata);
            failures++;
         end
         if (rsp_tlast !== want.last) begin
            $error("name_last: expected %b, got %b", want.last, rsp_tlast);
            failures++;
         end
         if (rsp_tuser !== want.truncated) begin
            $error("name_truncated: expected %b, got %b", want.truncated, rsp_tuser);
            failures++;
         end
      end
   endfunction

   // The receiver takes each name word and decides its readiness for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_word();
      if (hold_done != hold_asks) begin
         hold_left = HOLD_LEN;
         hold_done = hold_asks;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_word(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, eof);
   endtask

   task automatic send_file();
      for (int i = 0; i < src_bytes.size(); i++) begin
         send_word(src_bytes[i], i == src_bytes.size() - 1);
      end
   endtask

   task automatic wait_for_names();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (name_words_due.size() != 0) @(posedge clock);
   endtask

   function void add_byte(input logic [7:0] b);
      src_bytes.insert(src_bytes.size(), b);
   endfunction

   function void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] rand_char();
      logic [7:0] c;
      case ($urandom_range(9))
         7: c = "_";
         8: c = ".";
         9: c = 8'($urandom_range(255));
         default: c = 8'("a" + $urandom_range(25));
      endcase
      return c;
   endfunction

   function void add_letters(input int unsigned n);
      repeat (n) add_byte(8'("a" + $urandom_range(25)));
   endfunction

   function void add_use_statement();
      int unsigned r;
      int unsigned name_len;
      r = $urandom_range(99);
      if (r < 5) name_len = 0;
      else if (r < 10) name_len = $urandom_range(72, 60);
      else name_len = $urandom_range(10, 1);
      if ($urandom_range(4) != 0) begin
         case ($urandom_range(4))
            0: add_byte(CHAR_NL);
            1: add_byte(CHAR_SPACE);
            2: add_byte(CHAR_TAB);
            3: add_byte(CHAR_SEMI);
            default: add_byte(CHAR_RBRACE);
         endcase
      end
      add_text("use ");
      repeat ($urandom_range(2)) add_byte($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      repeat (name_len) add_byte(rand_char());
      repeat ($urandom_range(2)) begin
         case ($urandom_range(2))
            0: add_byte(CHAR_SPACE);
            1: add_byte(CHAR_TAB);
            default: add_byte(CHAR_CR);
         endcase
      end
      case ($urandom_range(2))
         0: add_byte(CHAR_SEMI);
         1: add_byte(CHAR_NL);
         default: ;
      endcase
   endfunction

   function void add_fragment();
      case ($urandom_range(9))
         4: begin
            add_text("//");
            repeat ($urandom_range(6)) add_byte(8'($urandom_range(255)));
            add_byte(CHAR_NL);
         end
         5: begin
            add_text("/*");
            repeat ($urandom_range(6)) begin
               case ($urandom_range(3))
                  0: add_byte(CHAR_STAR);
                  1: add_byte(CHAR_SLASH);
                  2: add_byte(CHAR_U);
                  default: add_byte(rand_char());
               endcase
            end
            add_text("*/");
         end
         6: begin
            add_byte(CHAR_QUOTE);
            repeat ($urandom_range(6)) begin
               case ($urandom_range(3))
                  0: begin
                     add_byte(CHAR_BSLASH);
                     add_byte(8'($urandom_range(255)));
                  end
                  1: add_byte(CHAR_SEMI);
                  2: add_byte(CHAR_NL);
                  default: add_byte(rand_char());
               endcase
            end
            add_byte(CHAR_QUOTE);
         end
         7: begin
            case ($urandom_range(2))
               0: add_text("u");
               1: add_text("us");
               default: add_text("use");
            endcase
            add_byte(rand_char());
         end
         8: begin
            add_byte(CHAR_SLASH);
            add_byte(rand_char());
         end
         9: repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)));
         default: add_use_statement();
      endcase
   endfunction

   function void build_file();
      int unsigned cut;
      src_bytes.delete();
      repeat ($urandom_range(6, 1)) add_fragment();
      if ($urandom_range(4) == 0 && src_bytes.size() > 1) begin
         cut = $urandom_range(src_bytes.size() - 1, 1);
         repeat (cut) src_bytes.delete(src_bytes.size() - 1);
      end
   endfunction

   task automatic test_directed();
      src_bytes.delete();
      add_text("use \t");
      add_byte(8'hFF);
      add_byte(8'h00);
      add_text(" \r;}use q");
      send_file();
      src_bytes.delete();
      add_text("/*/u*/use t");
      send_file();
      src_bytes.delete();
      add_text("\"\\\"\"//c\nuse s");
      send_file();
      wait_for_names();
   endtask

   task automatic test_long_names();
      src_bytes.delete();
      add_text("use ");
      add_letters(NAME_CAP);
      add_text("  \t\nuse ");
      add_letters(NAME_CAP + 6);
      send_file();
      wait_for_names();
   endtask

   task automatic test_random(input int unsigned budget);
      int unsigned sent;
      sent = 0;
      while (sent < budget) begin
         build_file();
         send_file();
         sent += src_bytes.size();
      end
      wait_for_names();
   endtask

   // The receiver holds off while several names queue up behind the scanner.
   task automatic test_backpressure();
      src_bytes.delete();
      hold_asks++;
      repeat (4) begin
         add_text("use ");
         add_letters(10);
         add_byte(CHAR_SEMI);
      end
      send_file();
      wait_for_names();
   endtask

   initial begin
      int unsigned waited;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      reset_scanner();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 68;
      test_directed();
      test_long_names();
      test_random(20);
      send_idle_pct = 68;
      recv_idle_pct = 11;
      test_random(20);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(20);

      req_tvalid <= 1'b0;
      waited = 0;
      while (name_words_due.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (name_words_due.size() != 0) begin
         $error("%0d name words never arrived", name_words_due.size());
         failures++;
      end
      repeat (150) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
